FILE: design/dsd_pkg.sv
package dsd_pkg;

    // packet size limit for the segment walk
    localparam int MAX_PACKET_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    // committed length never narrower than 17 bits so saturation works
    localparam int CMT_W            = (POS_W > 17) ? POS_W : 17;

    localparam logic [7:0] SYNC_BYTE   = 8'h0f;
    localparam int         SEG_HDR     = 6;
    localparam int         SKIP_BYTES  = 2;
    localparam int         TS_W        = 48;
    localparam int         DUR_W       = 49;
    localparam int         LEN_W       = 16;

    // action codes
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // segment header walk positions
    localparam logic [2:0] IDX_SYNC    = 3'd0;
    localparam logic [2:0] IDX_LEN_HI  = 3'd4;
    localparam logic [2:0] IDX_LEN_LO  = 3'd5;
    localparam logic [2:0] IDX_PAYLOAD = 3'd6;

    // config register map
    localparam int         REG_ADDR_W      = 3;
    localparam logic [0:0] REG_DEFAULT_DUR = 1'b0;
    localparam logic [31:0] DEFAULT_DUR_RST = 32'd120000000;

    typedef enum logic [1:0] {
        EV_KEEP    = 2'd0,
        EV_RELEASE = 2'd1,
        EV_FLUSH   = 2'd2
    } t_ev_kind;

    // front-to-back event; for a release, tsv/ts carry the next packet's stamp
    typedef struct packed {
        t_ev_kind          kind;
        logic [LEN_W-1:0]  len;
        logic              tsv;
        logic [TS_W-1:0]   ts;
        logic              durv;
        logic [TS_W-1:0]   dur;
    } t_evt;

    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic                    tsv;
        logic [TS_W-1:0]         ts;
        logic signed [DUR_W-1:0] dur;
    } t_res;

endpackage

FILE: design/dvb_subtitle_pes_deframer.sv
// A released result is registered first in the event queue and then in the result
// queue. Throughput: one input word per cycle while full is low; the front walker
// does one compare and counter update per word, and the event queue and result
// queue each hold two. Reset (i_rst_n, synchronous, active low) clears the walk,
// the held packet and both queues; default_duration_ns returns to 120000000.
module dvb_subtitle_pes_deframer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   i_action,
    input  logic [7:0]                             i_data_byte,
    input  logic                                   i_last_byte,
    input  logic                                   i_ts_valid,
    input  logic [47:0]                            i_timestamp_ns,
    input  logic                                   i_dur_valid,
    input  logic [47:0]                            i_own_duration_ns,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [15:0]                            o_kept_length,
    output logic                                   o_out_ts_valid,
    output logic [47:0]                            o_out_timestamp_ns,
    output logic signed [48:0]                     o_out_duration_ns,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dsd_pkg::REG_ADDR_W-1:0]         paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import dsd_pkg::*;

    logic [31:0] r_default_dur;
    logic        accept, evt_valid, q_empty, q_pop, reg_hit;
    t_evt        f_evt, q_evt;
    t_res        res;

    // config register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[REG_ADDR_W-1] == REG_DEFAULT_DUR);
    assign prdata  = reg_hit ? r_default_dur : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_dur <= DEFAULT_DUR_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_default_dur <= pwdata;
        end
    end

    assign accept = push && !full;

    dsd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_ts_valid       (i_ts_valid),
        .i_timestamp_ns   (i_timestamp_ns),
        .i_dur_valid      (i_dur_valid),
        .i_own_duration_ns(i_own_duration_ns),
        .o_evt_valid      (evt_valid),
        .o_evt            (f_evt)
    );

    dsd_evq u_evq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (evt_valid),
        .i_evt  (f_evt),
        .o_full (full),
        .i_pop  (q_pop),
        .o_evt  (q_evt),
        .o_empty(q_empty)
    );

    dsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_default_dur(r_default_dur),
        .i_evt        (q_evt),
        .i_evt_empty  (q_empty),
        .o_evt_pop    (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (res)
    );

    assign o_kept_length      = res.len;
    assign o_out_ts_valid     = res.tsv;
    assign o_out_timestamp_ns = res.ts;
    assign o_out_duration_ns  = res.dur;

endmodule

FILE: design/dsd_front.sv
module dsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_action,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_ts_valid,
    input  logic [47:0]         i_timestamp_ns,
    input  logic                i_dur_valid,
    input  logic [47:0]         i_own_duration_ns,
    output logic                o_evt_valid,
    output dsd_pkg::t_evt       o_evt
);
    import dsd_pkg::*;

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [2:0]        r_idx,   n_idx;
    logic [LEN_W-1:0]  r_hold,  n_hold;
    logic [LEN_W-1:0]  r_left,  n_left;
    logic              r_stop,  n_stop;
    logic [CMT_W-1:0]  r_cmt,   n_cmt;
    logic              r_pend,  n_pend;
    logic              r_mtsv,  n_mtsv;
    logic [TS_W-1:0]   r_mts,   n_mts;
    logic              r_mdurv, n_mdurv;
    logic [TS_W-1:0]   r_mdur,  n_mdur;
    logic [LEN_W-1:0]  left_dec;

    assign left_dec = r_left - LEN_W'(1);

    // per-word walk and event classification
    always_comb begin
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_hold  = r_hold;
        n_left  = r_left;
        n_stop  = r_stop;
        n_cmt   = r_cmt;
        n_pend  = r_pend;
        n_mtsv  = r_mtsv;
        n_mts   = r_mts;
        n_mdurv = r_mdurv;
        n_mdur  = r_mdur;
        o_evt_valid = 1'b0;
        o_evt       = '0;
        if (i_accept) begin
            if (i_action == ACT_FLUSH) begin
                if (r_pend) begin
                    o_evt_valid = 1'b1;
                    o_evt.kind  = EV_FLUSH;
                end
                n_pend = 1'b0;
                n_pos  = '0;
                n_idx  = IDX_SYNC;
                n_hold = '0;
                n_left = '0;
                n_stop = 1'b0;
                n_cmt  = '0;
            end else begin
                // first word: latch packet metadata, release the held packet
                if (r_pos == '0) begin
                    n_mtsv  = i_ts_valid;
                    n_mts   = i_timestamp_ns;
                    n_mdurv = i_dur_valid;
                    n_mdur  = i_own_duration_ns;
                    if (r_pend) begin
                        o_evt_valid = 1'b1;
                        o_evt.kind  = EV_RELEASE;
                        o_evt.tsv   = i_ts_valid;
                        o_evt.ts    = i_timestamp_ns;
                    end
                    n_pend = 1'b0;
                end
                // segment walk
                if (r_pos >= POS_W'(SKIP_BYTES) && r_pos < POS_W'(MAX_PACKET_BYTES)
                    && !r_stop) begin
                    case (r_idx)
                        IDX_SYNC: begin
                            if (i_data_byte != SYNC_BYTE) n_stop = 1'b1;
                            else                          n_idx  = 3'd1;
                        end
                        IDX_LEN_HI: begin
                            n_hold = {i_data_byte, 8'h00};
                            n_idx  = IDX_LEN_LO;
                        end
                        IDX_LEN_LO: begin
                            n_hold = {r_hold[15:8], i_data_byte};
                            if ({r_hold[15:8], i_data_byte} == '0) begin
                                n_cmt = r_cmt + CMT_W'(SEG_HDR);
                                n_idx = IDX_SYNC;
                            end else begin
                                n_left = {r_hold[15:8], i_data_byte};
                                n_idx  = IDX_PAYLOAD;
                            end
                        end
                        IDX_PAYLOAD: begin
                            if (r_left != '0) n_left = left_dec;
                            if (r_left == '0 || left_dec == '0) begin
                                n_cmt = r_cmt + CMT_W'(SEG_HDR) + CMT_W'(r_hold);
                                n_idx = IDX_SYNC;
                            end
                        end
                        default: begin
                            if (r_idx inside {[3'd1:3'd3]}) n_idx = r_idx + 3'd1;
                        end
                    endcase
                end
                if (r_pos < POS_W'(MAX_PACKET_BYTES)) n_pos = r_pos + POS_W'(1);
                // packet end: keep if a whole segment fit
                if (i_last_byte) begin
                    if (n_cmt != '0) begin
                        o_evt_valid = 1'b1;
                        o_evt.kind  = EV_KEEP;
                        o_evt.len   = (n_cmt > CMT_W'(16'hffff)) ? 16'hffff
                                                                 : n_cmt[LEN_W-1:0];
                        o_evt.tsv   = n_mtsv;
                        o_evt.ts    = n_mts;
                        o_evt.durv  = n_mdurv;
                        o_evt.dur   = n_mdur;
                        n_pend      = 1'b1;
                    end
                    n_pos  = '0;
                    n_idx  = IDX_SYNC;
                    n_hold = '0;
                    n_left = '0;
                    n_stop = 1'b0;
                    n_cmt  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idx   <= IDX_SYNC;
            r_hold  <= '0;
            r_left  <= '0;
            r_stop  <= 1'b0;
            r_cmt   <= '0;
            r_pend  <= 1'b0;
            r_mtsv  <= 1'b0;
            r_mts   <= '0;
            r_mdurv <= 1'b0;
            r_mdur  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_hold  <= n_hold;
            r_left  <= n_left;
            r_stop  <= n_stop;
            r_cmt   <= n_cmt;
            r_pend  <= n_pend;
            r_mtsv  <= n_mtsv;
            r_mts   <= n_mts;
            r_mdurv <= n_mdurv;
            r_mdur  <= n_mdur;
        end
    end

endmodule

FILE: design/dsd_evq.sv
module dsd_evq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsd_pkg::t_evt  i_evt,
    output logic           o_full,
    input  logic           i_pop,
    output dsd_pkg::t_evt  o_evt,
    output logic           o_empty
);
    import dsd_pkg::*;

    t_evt       r_mem [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rd];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 2'd1;
        if (!do_push && do_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/dsd_back.sv
module dsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_default_dur,
    input  dsd_pkg::t_evt  i_evt,
    input  logic           i_evt_empty,
    output logic           o_evt_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output dsd_pkg::t_res  o_res
);
    import dsd_pkg::*;

    // held packet
    logic [LEN_W-1:0] r_plen;
    logic             r_ptsv;
    logic [TS_W-1:0]  r_pts;
    logic             r_pdurv;
    logic [TS_W-1:0]  r_pdur;

    // result queue
    t_res       r_oq [2];
    logic       r_ord, r_owr;
    logic [1:0] r_ocnt, n_ocnt;

    logic       out_pop, out_room, is_keep, res_push;
    t_res       res;

    assign o_empty  = (r_ocnt == 2'd0);
    assign o_res    = r_oq[r_ord];
    assign out_pop  = i_pop && !o_empty;
    assign out_room = (r_ocnt != 2'd2) || out_pop;
    assign is_keep  = (i_evt.kind == EV_KEEP);
    assign o_evt_pop = !i_evt_empty && (is_keep || out_room);
    assign res_push  = o_evt_pop && !is_keep;

    // duration choice for the released packet
    always_comb begin
        res.len = r_plen;
        res.tsv = r_ptsv;
        res.ts  = r_ptsv ? r_pts : '0;
        if (r_pdurv)
            res.dur = signed'({1'b0, r_pdur});
        else if (r_ptsv && i_evt.kind == EV_RELEASE && i_evt.tsv)
            res.dur = signed'({1'b0, i_evt.ts} - {1'b0, r_pts});
        else
            res.dur = signed'(DUR_W'(i_default_dur));
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (res_push && !out_pop) n_ocnt = r_ocnt + 2'd1;
        if (!res_push && out_pop) n_ocnt = r_ocnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (o_evt_pop && is_keep) begin
            r_plen  <= i_evt.len;
            r_ptsv  <= i_evt.tsv;
            r_pts   <= i_evt.ts;
            r_pdurv <= i_evt.durv;
            r_pdur  <= i_evt.dur;
        end
        if (res_push) r_oq[r_owr] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord  <= 1'b0;
            r_owr  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (res_push) r_owr <= ~r_owr;
            if (out_pop)  r_ord <= ~r_ord;
            r_ocnt <= n_ocnt;
        end
    end

endmodule
